### design/tga_pkg.sv
package tga_pkg;

    // One byte of the file stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } tga_in_t;

    // One decoded result
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] pixel_data;
        logic [2:0]  pixel_bytes;
        logic [15:0] column;
        logic [15:0] row;
        logic        last;
    } tga_out_t;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Header byte positions
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_PIX_DEPTH = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;
    localparam logic [4:0] HDR_LAST      = HDR_DESC;

    localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_16           = 8'd16;
    localparam logic [7:0] DEPTH_24           = 8'd24;
    localparam logic [7:0] DEPTH_32           = 8'd32;
    localparam logic [3:0] ATTR_BITS_32       = 4'd8;

    // Descriptor bit positions
    localparam int DESC_FLIP_BIT   = 5;
    localparam int DESC_RSVD_BIT   = 4;

endpackage

### design/tga_parse.sv
module tga_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tga_pkg::tga_in_t  item,
    output logic              res_valid,
    output tga_pkg::tga_out_t res
);
    import tga_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_DATA,
        PH_DONE,
        PH_REJECTED
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [4:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]  id_len_reg,   id_len_next;
    logic [7:0]  cmap_reg,     cmap_next;
    logic [7:0]  itype_reg,    itype_next;
    logic [15:0] width_reg,    width_next;
    logic [15:0] height_reg,   height_next;
    logic [7:0]  pbits_reg,    pbits_next;
    logic [7:0]  desc_reg,     desc_next;
    logic [7:0]  id_rem_reg,   id_rem_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [23:0] asm_reg,      asm_next;
    logic [15:0] col_reg,      col_next;
    logic [15:0] line_reg,     line_next;

    phase_t      cur_phase;
    logic [4:0]  cur_cnt;
    logic [7:0]  b;
    logic        hdr_ok;
    logic [1:0]  last_idx;
    logic [16:0] col_inc;
    logic [16:0] line_inc;
    logic        pix_last;

    assign b         = item.data_byte;
    // start of file restarts the header capture with this byte
    assign cur_phase = item.start_of_file ? PH_HEADER : phase_reg;
    assign cur_cnt   = item.start_of_file ? 5'd0 : hdr_cnt_reg;

    // Checked on the descriptor byte itself, which is the current byte
    always_comb
    begin
        hdr_ok = (cmap_reg <= 8'd1) && (itype_reg == IMG_TYPE_TRUECOLOR)
                 && !b[DESC_RSVD_BIT] && (b[7:6] == 2'd0);
        if (pbits_reg == DEPTH_16)
            hdr_ok = hdr_ok && (b[3:0] <= 4'd1);
        else if (pbits_reg == DEPTH_24)
            hdr_ok = hdr_ok && (b[3:0] == 4'd0);
        else if (pbits_reg == DEPTH_32)
            hdr_ok = hdr_ok && (b[3:0] == ATTR_BITS_32);
        else
            hdr_ok = 1'b0;
    end

    always_comb
    begin
        if (pbits_reg == DEPTH_16)
            last_idx = 2'd1;
        else if (pbits_reg == DEPTH_24)
            last_idx = 2'd2;
        else
            last_idx = 2'd3;
    end

    assign col_inc  = {1'b0, col_reg} + 17'd1;
    assign line_inc = {1'b0, line_reg} + 17'd1;
    assign pix_last = (col_inc == {1'b0, width_reg}) && (line_inc == {1'b0, height_reg});

    always_comb
    begin
        phase_next    = cur_phase;
        hdr_cnt_next  = cur_cnt;
        id_len_next   = id_len_reg;
        cmap_next     = cmap_reg;
        itype_next    = itype_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        pbits_next    = pbits_reg;
        desc_next     = desc_reg;
        id_rem_next   = id_rem_reg;
        byte_idx_next = byte_idx_reg;
        asm_next      = asm_reg;
        col_next      = col_reg;
        line_next     = line_reg;
        res_valid     = 1'b0;
        res           = '0;

        unique case (cur_phase)
            PH_HEADER:
            begin
                unique case (cur_cnt)
                    HDR_ID_LEN:    id_len_next        = b;
                    HDR_CMAP_TYPE: cmap_next          = b;
                    HDR_IMG_TYPE:  itype_next         = b;
                    HDR_WIDTH_LO:  width_next[7:0]    = b;
                    HDR_WIDTH_HI:  width_next[15:8]   = b;
                    HDR_HEIGHT_LO: height_next[7:0]   = b;
                    HDR_HEIGHT_HI: height_next[15:8]  = b;
                    HDR_PIX_DEPTH: pbits_next         = b;
                    HDR_DESC:      desc_next          = b;
                    default: ;
                endcase
                if (cur_cnt != HDR_LAST)
                begin
                    hdr_cnt_next = cur_cnt + 5'd1;
                end
                else
                begin
                    hdr_cnt_next = 5'd0;
                    res_valid    = 1'b1;
                    if (!hdr_ok)
                    begin
                        phase_next      = PH_REJECTED;
                        res.result_kind = KIND_REJECT;
                    end
                    else
                    begin
                        res.result_kind = KIND_ACCEPT;
                        byte_idx_next   = 2'd0;
                        asm_next        = '0;
                        col_next        = '0;
                        line_next       = '0;
                        if (width_reg == 16'd0 || height_reg == 16'd0)
                        begin
                            phase_next = PH_DONE;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            id_rem_next = id_len_reg;
                            phase_next  = (id_len_reg != 8'd0) ? PH_ID : PH_DATA;
                        end
                    end
                end
            end
            PH_ID:
            begin
                id_rem_next = id_rem_reg - 8'd1;
                if (id_rem_next == 8'd0)
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (byte_idx_reg != last_idx)
                begin
                    unique case (byte_idx_reg)
                        2'd0:    asm_next[7:0]   = b;
                        2'd1:    asm_next[15:8]  = b;
                        2'd2:    asm_next[23:16] = b;
                        default: ;
                    endcase
                    byte_idx_next = byte_idx_reg + 2'd1;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_PIXEL;
                    res.pixel_bytes = {1'b0, last_idx} + 3'd1;
                    // swap bytes 0 and 2 on 24- and 32-bit pixels
                    unique case (last_idx)
                        2'd1:    res.pixel_data = {16'h0, b, asm_reg[7:0]};
                        2'd2:    res.pixel_data = {8'h0, asm_reg[7:0], asm_reg[15:8], b};
                        default: res.pixel_data = {b, asm_reg[7:0], asm_reg[15:8],
                                                   asm_reg[23:16]};
                    endcase
                    res.column = col_reg;
                    res.row    = desc_reg[DESC_FLIP_BIT] ? (height_reg - 16'd1 - line_reg)
                                                         : line_reg;
                    res.last   = pix_last;
                    byte_idx_next = 2'd0;
                    asm_next      = '0;
                    if (col_inc >= {1'b0, width_reg})
                    begin
                        col_next  = '0;
                        line_next = line_inc[15:0];
                    end
                    else
                    begin
                        col_next = col_inc[15:0];
                    end
                    if (pix_last)
                        phase_next = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            id_len_reg   <= '0;
            cmap_reg     <= '0;
            itype_reg    <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            pbits_reg    <= '0;
            desc_reg     <= '0;
            id_rem_reg   <= '0;
            byte_idx_reg <= '0;
            asm_reg      <= '0;
            col_reg      <= '0;
            line_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            id_len_reg   <= id_len_next;
            cmap_reg     <= cmap_next;
            itype_reg    <= itype_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            pbits_reg    <= pbits_next;
            desc_reg     <= desc_next;
            id_rem_reg   <= id_rem_next;
            byte_idx_reg <= byte_idx_next;
            asm_reg      <= asm_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
        end
    end

    a_pixel_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.result_kind == KIND_PIXEL
        |-> !item.start_of_file && phase_reg == PH_DATA)
        else $error("pixel produced outside the data phase");

    a_header_on_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.result_kind != KIND_PIXEL
        |-> !item.start_of_file && hdr_cnt_reg == HDR_LAST)
        else $error("header verdict before the descriptor byte");

    a_byte_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> byte_idx_reg <= last_idx)
        else $error("pixel byte index past the pixel size");

endmodule

### design/tga_out_stage.sv
module tga_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              res_valid,
    input  tga_pkg::tga_out_t res,
    output logic              room,
    output logic              valid,
    input  logic              stall,
    output tga_pkg::tga_out_t data
);
    import tga_pkg::*;

    logic     valid_reg;
    tga_out_t data_reg;

    // free when empty or when the held result transfers this cycle
    assign room  = !valid_reg || !stall;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (room)
            valid_reg <= load && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (room && load && res_valid)
            data_reg <= res;
    end

endmodule

### design/tga_truecolor_stream_decoder_core.sv
// TGA uncompressed true-color stream decoder.
// Input channel (in_valid / in_stall / in_data): one file byte per transfer,
// with start_of_file set on the first header byte of each file.
// Output channel (out_valid / out_stall / out_data): zero or one result per
// byte: a header verdict (accepted or rejected) after byte 17, then one pixel
// per 2, 3 or 4 data bytes with its column and destination row.
// The byte that completes a result passes through the input register, then the result
// register, before out_valid rises.
// Throughput: one byte per cycle unless a result is stalled; no bubbles between files.
// Both stages are single registers; the parser updates its header and pixel
// counters in the same cycle the byte leaves the input register.
// When out_stall is high with a result held, the parser stops and the input
// register keeps its byte; in_stall rises only while that byte is waiting.
// Reset clears both valid flags and puts the parser back to header capture;
// bytes after a rejected header, an empty image's header or the final pixel are
// dropped until the next start_of_file.
module tga_truecolor_stream_decoder_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tga_pkg::tga_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output tga_pkg::tga_out_t out_data
);
    import tga_pkg::*;

    logic     in_valid_reg;
    tga_in_t  in_data_reg;
    logic     room;
    logic     advance;
    logic     res_valid;
    tga_out_t res;

    // advance the held byte whenever the result register can take its result
    assign advance  = in_valid_reg && room;
    // hold the input only while a byte waits on a stalled result
    assign in_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= in_data;
    end

    tga_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tga_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid && out_stall)
        else $error("input stalled without a blocked byte");

    a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> out_valid)
        else $error("result lost between parser and result register");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule
